### design/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; the caller supplies a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/ttsd_pkg.sv
// Constants and the segment encoder for the temperature display block.
// No dependencies; used by the top level and its checker.
package ttsd_pkg;

  localparam int SampleW = 10;
  localparam int TenthsW = 13;
  localparam int SegW    = 8;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  localparam logic [SampleW-1:0] RED_RESET   = 10'd68;
  localparam logic [SampleW-1:0] GREEN_RESET = 10'd52;
  localparam logic [SampleW-1:0] BLUE_RESET  = 10'd37;

  // tenths = (s*10000 + 1023) / 2046, done as one multiply by a reciprocal
  // of 2046 scaled by 2^35. The reciprocal error keeps the result exact
  // for every numerator below 2^24.
  localparam int          TenthsShift = 35;
  localparam logic [47:0] TENTHS_MUL  = 48'd167936170000;
  localparam logic [47:0] TENTHS_ADD  = 48'd17179870191;

  // Reciprocals for the digit split, exact for values up to 5000.
  localparam logic [28:0] DIV10_MUL   = 29'd52429;
  localparam logic [28:0] DIV100_MUL  = 29'd41944;
  localparam logic [26:0] DIV1000_MUL = 27'd8389;

  localparam logic [SegW-1:0] SEG_DP = 8'h80;

  function automatic logic [SegW-1:0] seg_encode(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

### design/temperature_to_segment_display.sv
// Converts a raw sensor sample to tenths of a degree, three segment codes
// and a priority colour output. Throughput is one request per cycle unless
// in_stall is high. The result passes through three registers (input,
// scaled value, result) around the reciprocal multiply and the digit split.
// A stalled output holds each full stage that has no empty stage ahead of
// it, and the input stalls only once all three stages are full.
// Reset clears all valid flags and loads thresholds 68, 52 and 37.
module temperature_to_segment_display
  import ttsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SampleW-1:0] adc_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TenthsW-1:0] temp_tenths,
  output logic [SegW-1:0]    seg_left,
  output logic [SegW-1:0]    seg_middle,
  output logic [SegW-1:0]    seg_right,
  output logic               led_red,
  output logic               led_green,
  output logic               led_blue,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [SampleW-1:0] cfg_data
);

  logic [SampleW-1:0] red_thr, green_thr, blue_thr;

  logic               v0, v1, v2;
  logic               adv0, adv1, adv2;
  logic [SampleW-1:0] sample0;
  logic [TenthsW-1:0] tenths1;
  logic [2:0]         leds1;

  logic [47:0]        scaled;
  logic [TenthsW-1:0] tenths_next;
  logic               red_hit, green_hit, blue_hit;
  logic [2:0]         leds_next;

  logic [28:0]        p10, p100;
  logic [26:0]        p1000;
  logic [9:0]         q10;
  logic [6:0]         q100;
  logic [3:0]         q1000;
  logic [12:0]        units_full;
  logic [9:0]         tens_full;
  logic [6:0]         hund_full;
  logic [SegW-1:0]    left_next, middle_next, right_next;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_thr   <= RED_RESET;
      green_thr <= GREEN_RESET;
      blue_thr  <= BLUE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED:   red_thr   <= cfg_data;
        REG_GREEN: green_thr <= cfg_data;
        REG_BLUE:  blue_thr  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // A stage moves when the one after it is empty or moving too.
  assign adv2     = !v2 || !out_stall;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign in_stall = !adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  // Scaling and colour decision.
  always_comb begin
    scaled      = 48'(sample0) * TENTHS_MUL + TENTHS_ADD;
    tenths_next = scaled[TenthsShift +: TenthsW];
    red_hit     = sample0 >= red_thr;
    green_hit   = !red_hit && (sample0 >= green_thr);
    blue_hit    = !red_hit && !green_hit && (sample0 >= blue_thr);
    leds_next   = {red_hit, green_hit, blue_hit};
  end

  // Digit split: quotients by 10, 100 and 1000 in parallel, then each digit
  // is the quotient minus ten times the next one up. The thousands digit
  // falls away here.
  always_comb begin
    p10        = 29'(tenths1) * DIV10_MUL;
    p100       = 29'(tenths1) * DIV100_MUL;
    p1000      = 27'(tenths1) * DIV1000_MUL;
    q10        = p10[28:19];
    q100       = p100[28:22];
    q1000      = p1000[26:23];
    units_full = tenths1 - 13'(q10) * 13'd10;
    tens_full  = q10 - 10'(q100) * 10'd10;
    hund_full  = q100 - 7'(q1000) * 7'd10;
    left_next   = (tenths1 < 13'd100) ? '0 : seg_encode(hund_full[3:0]);
    middle_next = seg_encode(tens_full[3:0]) | SEG_DP;
    right_next  = seg_encode(units_full[3:0]);
  end

  always_ff @(posedge clk) begin
    if (adv0) sample0 <= adc_sample;
    if (adv1) begin
      tenths1 <= tenths_next;
      leds1   <= leds_next;
    end
    if (adv2) begin
      temp_tenths <= tenths1;
      seg_left    <= left_next;
      seg_middle  <= middle_next;
      seg_right   <= right_next;
      led_red     <= leds1[2];
      led_green   <= leds1[1];
      led_blue    <= leds1[0];
    end
  end

  assign out_valid = v2;

endmodule

### design/ttsd_checker.sv
// Port-level checker for the temperature display block, with its bind.
// Depends on ttsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttsd_checker
  import ttsd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [TenthsW-1:0] temp_tenths,
  input logic [SegW-1:0]    seg_left,
  input logic [SegW-1:0]    seg_middle,
  input logic               led_red,
  input logic               led_green,
  input logic               led_blue
);

  logic [2:0] leds;
  logic       blank_zone;
  logic       held;

  assign leds       = {led_red, led_green, led_blue};
  assign blank_zone = out_valid && (temp_tenths < 13'd100);
  assign held       = out_valid && out_stall;

  // At most one colour lights for a result.
  `ASSERT_SAME(a_led_onehot, out_valid, $onehot0(leds), "more than one colour lit")
  // The middle digit always carries the decimal point.
  `ASSERT_SAME(a_dp_set, out_valid, (seg_middle & SEG_DP) == SEG_DP, "decimal point missing")
  // Below ten degrees the left digit is blank, and the value never exceeds 500.0.
  `ASSERT_SAME(a_left_blank, blank_zone, seg_left == '0, "left digit not blanked")
  `ASSERT_SAME(a_range, out_valid, temp_tenths <= 13'd5000, "temperature out of range")
  // A stalled result stays in place.
  `ASSERT_NEXT(a_hold, held, out_valid && $stable(temp_tenths), "stalled result changed")

endmodule

bind temperature_to_segment_display ttsd_checker u_ttsd_checker (.*);

### bench/tb_top.sv
// Self-checking bench for temperature_to_segment_display: samples in, display codes out.
// Depends on ttsd_pkg and the block's RTL. It predicts each result from its own model.
`timescale 1ns / 1ps

module tb_top;
  import ttsd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [TenthsW-1:0] tenths;
    logic [SegW-1:0]    left;
    logic [SegW-1:0]    middle;
    logic [SegW-1:0]    right;
    logic               red;
    logic               green;
    logic               blue;
  } display_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SampleW-1:0] adc_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TenthsW-1:0] temp_tenths;
  logic [SegW-1:0]    seg_left;
  logic [SegW-1:0]    seg_middle;
  logic [SegW-1:0]    seg_right;
  logic               led_red;
  logic               led_green;
  logic               led_blue;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [SampleW-1:0] cfg_data = '0;

  // Segment patterns for digits 0 to 9, segment a in bit 0.
  logic [SegW-1:0] digit_segments [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                           8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  logic [SampleW-1:0] red_level = RED_RESET;
  logic [SampleW-1:0] green_level = GREEN_RESET;
  logic [SampleW-1:0] blue_level = BLUE_RESET;

  display_result_t pending_displays [$];
  int fail_count = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int settings_used = 1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  temperature_to_segment_display dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .temp_tenths(temp_tenths), .seg_left(seg_left), .seg_middle(seg_middle),
    .seg_right(seg_right), .led_red(led_red), .led_green(led_green), .led_blue(led_blue),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic display_result_t predict_display(input logic [SampleW-1:0] s);
    display_result_t r;
    int unsigned sv;
    int unsigned t;
    sv = s;
    t = (sv * 10000 + 1023) / 2046;
    r.tenths = t[TenthsW-1:0];
    r.left = (t < 100) ? '0 : digit_segments[(t / 100) % 10];
    r.middle = digit_segments[(t / 10) % 10] | SEG_DP;
    r.right = digit_segments[t % 10];
    r.red = (s >= red_level);
    r.green = !r.red && (s >= green_level);
    r.blue = !r.red && !r.green && (s >= blue_level);
    return r;
  endfunction

  // The receiver stalls at random, or solidly while a hold-off count runs down.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_result
    display_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_displays.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none got temp %0d",
                 $time, temp_tenths);
        fail_count++;
      end else begin
        want = pending_displays.pop_front();
        results_checked++;
        check_field("temp_tenths", want.tenths, temp_tenths);
        check_field("seg_left", want.left, seg_left);
        check_field("seg_middle", want.middle, seg_middle);
        check_field("seg_right", want.right, seg_right);
        check_field("led_red", want.red, led_red);
        check_field("led_green", want.green, led_green);
        check_field("led_blue", want.blue, led_blue);
      end
    end
  end

  // Offers one request, possibly after idle cycles, and records its prediction
  // once accepted. Valid is left high so back-to-back requests need no gap.
  task automatic send_sample(input logic [SampleW-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      adc_sample <= SampleW'($urandom_range(1023));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_displays.push_back(predict_display(s));
    samples_sent++;
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [SampleW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_RED:   red_level = value;
      REG_GREEN: green_level = value;
      REG_BLUE:  blue_level = value;
      default:   ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [SampleW-1:0] r, input logic [SampleW-1:0] g,
                                input logic [SampleW-1:0] b);
    write_register(REG_RED, r);
    write_register(REG_GREEN, g);
    write_register(REG_BLUE, b);
    settings_used++;
  endtask

  function automatic logic [SampleW-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom_range(1023));
    endcase
  endfunction

  // Mostly uniform samples, with extra weight near the thresholds and the
  // points where the display blanks or drops its thousands digit.
  function automatic logic [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0: v = red_level + $urandom_range(4) - 2;
      1: v = green_level + $urandom_range(4) - 2;
      2: v = blue_level + $urandom_range(4) - 2;
      3: begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 1023;
          2: v = 20 + $urandom_range(1);
          default: v = 204 + $urandom_range(2);
        endcase
      end
      default: v = $urandom_range(1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SampleW-1:0];
  endfunction

  task automatic test_reset_thresholds();
    logic [SampleW-1:0] points [14] = '{10'd0, 10'd1, 10'd20, 10'd21, 10'd36, 10'd37,
                                        10'd51, 10'd52, 10'd67, 10'd68, 10'd204,
                                        10'd205, 10'd1022, 10'd1023};
    foreach (points[i]) send_sample(points[i]);
    stop_and_drain();
  endtask

  task automatic test_register_writes();
    // Green below everything with red and blue at the top: green wins but for 1023.
    set_thresholds(10'd1023, 10'd0, 10'd1023);
    send_sample(10'd0);
    send_sample(10'd512);
    send_sample(10'd1023);
    stop_and_drain();
    write_register(REG_RED, 10'd0);
    send_sample(10'd0);
    stop_and_drain();
    // A write to the unused index must leave every threshold alone.
    write_register(REG_UNUSED, 10'd5);
    set_thresholds(10'd900, 10'd1000, 10'd100);
    send_sample(10'd99);
    send_sample(10'd100);
    send_sample(10'd950);
    send_sample(10'd1000);
    stop_and_drain();
    set_thresholds(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd1022);
    send_sample(10'd1023);
    stop_and_drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int half = 0; half < 2; half++) begin
      set_thresholds(pick_threshold(), pick_threshold(), pick_threshold());
      for (int i = 0; i < count / 2; i++) send_sample(pick_sample());
      stop_and_drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back,
  // then the sender pauses until everything has come out before resuming.
  task automatic test_backpressure();
    set_thresholds(10'd600, 10'd300, 10'd100);
    hold_left = 80;
    for (int i = 0; i < 30; i++) send_sample(SampleW'($urandom_range(1023)));
    stop_and_drain();
    for (int i = 0; i < 10; i++) send_sample(SampleW'($urandom_range(1023)));
    stop_and_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_thresholds();
    test_register_writes();
    test_random_traffic(0, 0, 360);
    test_random_traffic(65, 0, 360);
    test_random_traffic(0, 65, 360);
    test_random_traffic(26, 26, 360);
    test_backpressure();
    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d requests over %0d threshold settings,",
             results_checked, samples_sent, settings_used);
    $display("with idle and stall phases, a long output hold-off and drain pauses.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
